[hw/rtl/bmpd_pkg.sv]
// Package for the BMP texture decoder: size limits, derived widths, result
// codes and the pixel request record passed from the parser to the output stage.
// No dependencies.
package bmpd_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 2048;

    // Dimension registers hold values up to the limit itself.
    localparam int WDIM_W = $clog2(MAX_WIDTH + 1);
    localparam int HDIM_W = $clog2(MAX_HEIGHT + 1);

    localparam int COORD_W   = 11;
    localparam int CHAN_W    = 8;
    localparam int TBL_DEPTH = 256;
    localparam int TBL_AW    = $clog2(TBL_DEPTH);

    localparam logic [1:0] ERR_NONE   = 2'd0;
    localparam logic [1:0] ERR_HEADER = 2'd1;
    localparam logic [1:0] ERR_TYPE   = 2'd2;
    localparam logic [1:0] ERR_SIZE   = 2'd3;

    localparam logic FMT_LUM_ALPHA = 1'b0;
    localparam logic FMT_RGBA      = 1'b1;

    typedef struct packed {
        logic [1:0]         error_code;
        logic               lookup;       // color comes from the intensity table
        logic               pixel_format;
        logic [CHAN_W-1:0]  red;
        logic [CHAN_W-1:0]  green;
        logic [CHAN_W-1:0]  blue;
        logic [CHAN_W-1:0]  alpha;
        logic [COORD_W-1:0] column;
        logic [COORD_W-1:0] row;
        logic               last_pixel;
    } bmpd_req_t;

endpackage

[hw/rtl/bmpd_ram.sv]
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module bmpd_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH = 256,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hw/rtl/bmpd_parser.sv]
// Byte parser of the BMP texture decoder: header capture and check, palette to
// intensity table writes, row padding and pixel position tracking.
// Depends on bmpd_pkg.
module bmpd_parser (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    input  logic                       s_ready,
    input  logic [7:0]                 s_file_byte,
    input  logic                       s_start_of_file,
    input  logic                       use_luminance,
    output logic                       req_valid,
    output bmpd_pkg::bmpd_req_t        req,
    output logic                       tbl_wr_en,
    output logic [bmpd_pkg::TBL_AW-1:0] tbl_wr_addr,
    output logic [bmpd_pkg::CHAN_W-1:0] tbl_wr_data,
    output logic                       tbl_rd_en,
    output logic [bmpd_pkg::TBL_AW-1:0] tbl_rd_addr
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HEADER,
        PH_PALETTE,
        PH_PIXELS,
        PH_PAD,
        PH_DONE
    } phase_t;

    localparam int WDIM_W = bmpd_pkg::WDIM_W;
    localparam int HDIM_W = bmpd_pkg::HDIM_W;

    localparam int HDR_LEN  = 54;
    localparam int HDR_KEEP = 30;   // bytes 0..29 hold every checked field
    localparam int PAL_LEN  = 1024;

    localparam int OFS_SIG0   = 0;
    localparam int OFS_SIG1   = 1;
    localparam int OFS_DATA   = 10;
    localparam int OFS_INFO   = 14;
    localparam int OFS_WIDTH  = 18;
    localparam int OFS_HEIGHT = 22;
    localparam int OFS_PLANES = 26;
    localparam int OFS_BPP    = 28;

    localparam logic [7:0]  SIG_B        = 8'h42;
    localparam logic [7:0]  SIG_M        = 8'h4d;
    localparam logic [31:0] INFO_SIZE    = 32'h28;
    localparam logic [15:0] PLANES_ONE   = 16'd1;
    localparam logic [31:0] DATA_OFS_PAL = 32'h436;
    localparam logic [31:0] DATA_OFS_RGB = 32'h36;
    localparam logic [15:0] BPP_PAL      = 16'd8;
    localparam logic [15:0] BPP_RGB      = 16'd24;
    localparam logic [7:0]  ALPHA_KEY    = 8'd5;
    localparam logic [7:0]  ALPHA_ON     = 8'd255;

    // x / 3 for x <= 765 equals (x * 683) >> 11.
    localparam logic [9:0] DIV3_MUL   = 10'd683;
    localparam int         DIV3_SHIFT = 11;

    phase_t                  phase_reg, phase_next;
    logic [9:0]              cnt_reg, cnt_next;
    logic [HDR_KEEP*8-1:0]   hdr_reg, hdr_next;
    logic [9:0]              sum_reg, sum_next;
    logic [WDIM_W-1:0]       col_reg, col_next;
    logic [HDIM_W-1:0]       row_reg, row_next;
    logic [1:0]              pad_cnt_reg, pad_cnt_next;
    logic [1:0]              pad_len_reg, pad_len_next;
    logic [15:0]             part_reg, part_next;
    logic                    mode24_reg, mode24_next;
    logic                    topdown_reg, topdown_next;
    logic                    empty_reg, empty_next;
    logic [WDIM_W-1:0]       width_reg, width_next;
    logic [HDIM_W-1:0]       height_reg, height_next;

    logic        accept;
    phase_t      ph;
    logic [9:0]  cnt;

    logic [31:0] hdr_offset, hdr_info, hdr_width, hdr_height, h_mag;
    logic [15:0] hdr_planes, hdr_bpp;
    logic        hdr_ok, type_pal, type_rgb, too_big;
    logic [1:0]  row_bytes_lo;

    logic [9:0]  sum_total;
    logic [19:0] div_prod;

    logic              col_last, row_last, pix_last;
    logic [HDIM_W-1:0] row_img;
    logic [31:0]       col_wide, row_wide;
    logic [7:0]        alpha24;

    assign accept = s_valid && s_ready;

    assign hdr_offset = hdr_reg[OFS_DATA*8 +: 32];
    assign hdr_info   = hdr_reg[OFS_INFO*8 +: 32];
    assign hdr_width  = hdr_reg[OFS_WIDTH*8 +: 32];
    assign hdr_height = hdr_reg[OFS_HEIGHT*8 +: 32];
    assign hdr_planes = hdr_reg[OFS_PLANES*8 +: 16];
    assign hdr_bpp    = hdr_reg[OFS_BPP*8 +: 16];

    // A negative height marks a top-down file; its magnitude is the row count.
    assign h_mag = hdr_height[31] ? (32'd0 - hdr_height) : hdr_height;

    assign hdr_ok = (hdr_reg[OFS_SIG0*8 +: 8] == SIG_B) && (hdr_reg[OFS_SIG1*8 +: 8] == SIG_M)
                    && (hdr_info == INFO_SIZE) && (hdr_planes == PLANES_ONE);
    assign type_pal = (hdr_offset == DATA_OFS_PAL) && (hdr_bpp == BPP_PAL);
    assign type_rgb = (hdr_offset == DATA_OFS_RGB) && (hdr_bpp == BPP_RGB);
    assign too_big  = (hdr_width > 32'(bmpd_pkg::MAX_WIDTH))
                      || (h_mag > 32'(bmpd_pkg::MAX_HEIGHT));
    assign row_bytes_lo = type_rgb ? 2'(hdr_width[1:0] * 2'd3) : hdr_width[1:0];

    assign sum_total = 10'(sum_reg + 10'(s_file_byte));
    assign div_prod  = sum_total * DIV3_MUL;

    assign col_last = (WDIM_W'(col_reg + 1'b1) == width_reg);
    assign row_last = (HDIM_W'(row_reg + 1'b1) == height_reg);
    assign pix_last = col_last && row_last;
    assign row_img  = topdown_reg ? row_reg : HDIM_W'(height_reg - 1'b1 - row_reg);
    assign col_wide = 32'(col_reg);
    assign row_wide = 32'(row_img);
    assign alpha24  = ((part_reg[7:0] > ALPHA_KEY) || (part_reg[15:8] > ALPHA_KEY)
                       || (s_file_byte > ALPHA_KEY)) ? ALPHA_ON : 8'd0;

    always_comb begin
        ph  = s_start_of_file ? PH_HEADER : phase_reg;
        cnt = s_start_of_file ? 10'd0 : cnt_reg;

        phase_next   = phase_reg;
        cnt_next     = cnt_reg;
        hdr_next     = hdr_reg;
        sum_next     = sum_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        pad_cnt_next = pad_cnt_reg;
        pad_len_next = pad_len_reg;
        part_next    = part_reg;
        mode24_next  = mode24_reg;
        topdown_next = topdown_reg;
        empty_next   = empty_reg;
        width_next   = width_reg;
        height_next  = height_reg;

        req_valid   = 1'b0;
        req         = '0;
        tbl_wr_en   = 1'b0;
        tbl_wr_addr = cnt[9:2];
        tbl_wr_data = div_prod[DIV3_SHIFT +: 8];
        tbl_rd_en   = 1'b0;
        tbl_rd_addr = s_file_byte;

        if (accept) begin
            phase_next = ph;
            cnt_next   = cnt;
            unique case (ph)
                PH_HEADER: begin
                    if (cnt < 10'(HDR_KEEP)) begin
                        hdr_next = {s_file_byte, hdr_reg[HDR_KEEP*8-1:8]};
                    end
                    cnt_next = 10'(cnt + 1'b1);
                    if (cnt == 10'(HDR_LEN - 1)) begin
                        mode24_next  = type_rgb;
                        topdown_next = hdr_height[31];
                        width_next   = hdr_width[WDIM_W-1:0];
                        height_next  = h_mag[HDIM_W-1:0];
                        empty_next   = (hdr_width == 32'd0) || (h_mag == 32'd0);
                        pad_len_next = 2'd0 - row_bytes_lo;
                        col_next     = '0;
                        row_next     = '0;
                        cnt_next     = '0;
                        part_next    = '0;
                        sum_next     = '0;
                        if (!hdr_ok) begin
                            req_valid       = 1'b1;
                            req.error_code  = bmpd_pkg::ERR_HEADER;
                            phase_next      = PH_DONE;
                        end else if (!type_pal && !type_rgb) begin
                            req_valid       = 1'b1;
                            req.error_code  = bmpd_pkg::ERR_TYPE;
                            phase_next      = PH_DONE;
                        end else if (too_big) begin
                            req_valid       = 1'b1;
                            req.error_code  = bmpd_pkg::ERR_SIZE;
                            phase_next      = PH_DONE;
                        end else if (type_rgb) begin
                            phase_next = ((hdr_width == 32'd0) || (h_mag == 32'd0))
                                         ? PH_DONE : PH_PIXELS;
                        end else begin
                            phase_next = PH_PALETTE;
                        end
                    end
                end
                PH_PALETTE: begin
                    // Entries are blue, green, red, reserved.
                    case (cnt[1:0])
                        2'd0: sum_next = 10'(s_file_byte);
                        2'd1: sum_next = sum_total;
                        2'd2: begin
                            sum_next  = sum_total;
                            tbl_wr_en = 1'b1;
                        end
                        default: sum_next = sum_reg;
                    endcase
                    cnt_next = 10'(cnt + 1'b1);
                    if (cnt == 10'(PAL_LEN - 1)) begin
                        col_next   = '0;
                        row_next   = '0;
                        cnt_next   = '0;
                        part_next  = '0;
                        phase_next = empty_reg ? PH_DONE : PH_PIXELS;
                    end
                end
                PH_PIXELS: begin
                    if (mode24_reg && (cnt == 10'd0)) begin
                        part_next[7:0] = s_file_byte;
                        cnt_next       = 10'd1;
                    end else if (mode24_reg && (cnt == 10'd1)) begin
                        part_next[15:8] = s_file_byte;
                        cnt_next        = 10'd2;
                    end else begin
                        req_valid      = 1'b1;
                        req.error_code = bmpd_pkg::ERR_NONE;
                        req.column     = col_wide[bmpd_pkg::COORD_W-1:0];
                        req.row        = row_wide[bmpd_pkg::COORD_W-1:0];
                        req.last_pixel = pix_last;
                        if (mode24_reg) begin
                            req.pixel_format = bmpd_pkg::FMT_RGBA;
                            req.red          = s_file_byte;
                            req.green        = part_reg[15:8];
                            req.blue         = part_reg[7:0];
                            req.alpha        = alpha24;
                            cnt_next         = 10'd0;
                        end else begin
                            req.lookup       = 1'b1;
                            req.pixel_format = use_luminance ? bmpd_pkg::FMT_LUM_ALPHA
                                                             : bmpd_pkg::FMT_RGBA;
                            tbl_rd_en        = 1'b1;
                        end
                        if (col_last) begin
                            col_next = '0;
                            if (pix_last) begin
                                phase_next = PH_DONE;
                            end else if (pad_len_reg != 2'd0) begin
                                pad_cnt_next = pad_len_reg;
                                phase_next   = PH_PAD;
                            end else begin
                                row_next = HDIM_W'(row_reg + 1'b1);
                            end
                        end else begin
                            col_next = WDIM_W'(col_reg + 1'b1);
                        end
                    end
                end
                PH_PAD: begin
                    pad_cnt_next = 2'(pad_cnt_reg - 1'b1);
                    if (pad_cnt_reg == 2'd1) begin
                        row_next   = HDIM_W'(row_reg + 1'b1);
                        phase_next = PH_PIXELS;
                        cnt_next   = '0;
                    end
                end
                PH_IDLE, PH_DONE: begin
                    phase_next = ph;
                end
                default: begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            cnt_reg     <= '0;
            sum_reg     <= '0;
            col_reg     <= '0;
            row_reg     <= '0;
            pad_cnt_reg <= '0;
            part_reg    <= '0;
            mode24_reg  <= 1'b0;
            topdown_reg <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            cnt_reg     <= cnt_next;
            sum_reg     <= sum_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
            pad_cnt_reg <= pad_cnt_next;
            part_reg    <= part_next;
            mode24_reg  <= mode24_next;
            topdown_reg <= topdown_next;
        end
        hdr_reg     <= hdr_next;
        pad_len_reg <= pad_len_next;
        empty_reg   <= empty_next;
        width_reg   <= width_next;
        height_reg  <= height_next;
    end

    a_tbl_port_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        !(tbl_wr_en && tbl_rd_en))
        else $error("intensity table written and read in the same cycle");

    a_req_on_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        req_valid |-> (s_valid && s_ready))
        else $error("result item raised without an accepted byte");

    a_pad_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_PAD) |-> (pad_cnt_reg != 2'd0))
        else $error("padding phase entered with nothing to skip");

endmodule

[hw/rtl/bmpd_out.sv]
// Output stage of the BMP texture decoder: holds a request while the table read
// completes, then fills the color channels into the output register.
// Depends on bmpd_pkg.
module bmpd_out (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        req_valid,
    input  bmpd_pkg::bmpd_req_t         req,
    input  logic [bmpd_pkg::CHAN_W-1:0] tbl_rd_data,
    output logic                        s_ready,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_pixel_format,
    output logic [7:0]                  m_red,
    output logic [7:0]                  m_green,
    output logic [7:0]                  m_blue,
    output logic [7:0]                  m_alpha,
    output logic [10:0]                 m_column,
    output logic [10:0]                 m_row,
    output logic                        m_last_pixel,
    output logic [1:0]                  m_error_code
);

    logic                a_valid_reg;
    bmpd_pkg::bmpd_req_t a_req_reg;
    logic                m_valid_reg;
    bmpd_pkg::bmpd_req_t m_req_reg, m_req_next;
    logic                out_load;

    assign out_load = !m_valid_reg || m_ready;
    // The table data registered at accept stays put until the next lookup,
    // which can only be accepted as this item moves on.
    assign s_ready  = !a_valid_reg || out_load;

    always_comb begin
        m_req_next = a_req_reg;
        if (a_req_reg.lookup) begin
            m_req_next.red   = tbl_rd_data;
            m_req_next.alpha = tbl_rd_data;
            if (a_req_reg.pixel_format == bmpd_pkg::FMT_RGBA) begin
                m_req_next.green = tbl_rd_data;
                m_req_next.blue  = tbl_rd_data;
            end else begin
                m_req_next.green = '0;
                m_req_next.blue  = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                a_valid_reg <= req_valid;
            end
            if (out_load) begin
                m_valid_reg <= a_valid_reg;
            end
        end
        if (s_ready && req_valid) begin
            a_req_reg <= req;
        end
        if (out_load && a_valid_reg) begin
            m_req_reg <= m_req_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_pixel_format = m_req_reg.pixel_format;
    assign m_red          = m_req_reg.red;
    assign m_green        = m_req_reg.green;
    assign m_blue         = m_req_reg.blue;
    assign m_alpha        = m_req_reg.alpha;
    assign m_column       = m_req_reg.column;
    assign m_row          = m_req_reg.row;
    assign m_last_pixel   = m_req_reg.last_pixel;
    assign m_error_code   = m_req_reg.error_code;

    a_error_fields_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_error_code != bmpd_pkg::ERR_NONE)) |->
            (m_red == 8'd0 && m_green == 8'd0 && m_blue == 8'd0 && m_alpha == 8'd0
             && m_column == 11'd0 && m_row == 11'd0 && !m_last_pixel && !m_pixel_format))
        else $error("error item carries pixel data");

endmodule

[hw/rtl/bmp_texture_decoder.sv]
// BMP texture decoder, top level: parser, intensity table RAM and output stage.
// A pixel item is held in a_req_reg, then in m_req_reg, before it is valid at m_valid.
// Throughput: one file byte per cycle; the only stall comes from m_ready backpressure.
// Reset (synchronous, aresetn low) idles the parser until start_of_file and sets
// use_luminance to 1; the intensity table is not cleared, every palette rewrites it.
// Depends on bmpd_pkg, bmpd_ram, bmpd_parser and bmpd_out.
module bmp_texture_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_file_byte,
    input  logic        s_start_of_file,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_pixel_format,
    output logic [7:0]  m_red,
    output logic [7:0]  m_green,
    output logic [7:0]  m_blue,
    output logic [7:0]  m_alpha,
    output logic [10:0] m_column,
    output logic [10:0] m_row,
    output logic        m_last_pixel,
    output logic [1:0]  m_error_code
);

    logic                        use_lum_reg;
    logic                        req_valid;
    bmpd_pkg::bmpd_req_t         req;
    logic                        tbl_wr_en;
    logic [bmpd_pkg::TBL_AW-1:0] tbl_wr_addr;
    logic [bmpd_pkg::CHAN_W-1:0] tbl_wr_data;
    logic                        tbl_rd_en;
    logic [bmpd_pkg::TBL_AW-1:0] tbl_rd_addr;
    logic [bmpd_pkg::CHAN_W-1:0] tbl_rd_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            use_lum_reg <= 1'b1;
        end else if (cfg_wr_en) begin
            use_lum_reg <= cfg_wr_data;
        end
    end

    bmpd_parser u_parser (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_file_byte     (s_file_byte),
        .s_start_of_file (s_start_of_file),
        .use_luminance   (use_lum_reg),
        .req_valid       (req_valid),
        .req             (req),
        .tbl_wr_en       (tbl_wr_en),
        .tbl_wr_addr     (tbl_wr_addr),
        .tbl_wr_data     (tbl_wr_data),
        .tbl_rd_en       (tbl_rd_en),
        .tbl_rd_addr     (tbl_rd_addr)
    );

    bmpd_ram #(
        .DATA_W (bmpd_pkg::CHAN_W),
        .DEPTH  (bmpd_pkg::TBL_DEPTH)
    ) u_intensity_ram (
        .aclk    (aclk),
        .wr_en   (tbl_wr_en),
        .wr_addr (tbl_wr_addr),
        .wr_data (tbl_wr_data),
        .rd_en   (tbl_rd_en),
        .rd_addr (tbl_rd_addr),
        .rd_data (tbl_rd_data)
    );

    bmpd_out u_out (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .req_valid      (req_valid),
        .req            (req),
        .tbl_rd_data    (tbl_rd_data),
        .s_ready        (s_ready),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_pixel_format (m_pixel_format),
        .m_red          (m_red),
        .m_green        (m_green),
        .m_blue         (m_blue),
        .m_alpha        (m_alpha),
        .m_column       (m_column),
        .m_row          (m_row),
        .m_last_pixel   (m_last_pixel),
        .m_error_code   (m_error_code)
    );

endmodule
